FILE: sv/rad_pkg.sv
// Shared types and constants for the running average filter.
// No dependencies; imported by rad_window, running_average_filter and the testbench.
package rad_pkg;

  // Width of the window length register and its value after reset.
  localparam int CFG_W = 6;
  localparam logic [CFG_W-1:0] WINDOW_RESET = 6'd20;

  typedef logic [CFG_W-1:0] cfg_t;

endpackage

FILE: sv/rad_divider.sv
// Iterative restoring divider that yields one quotient bit per cycle.
// Standalone; used by running_average_filter for the sum / count step.
module rad_divider #(
  parameter int SUM_W = 21,
  parameter int CNT_W = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [SUM_W-1:0] quotient
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic              busy;
  logic [STEP_W-1:0] steps;
  logic [CNT_W-1:0]  rem;
  logic [SUM_W-1:0]  quo;
  logic [CNT_W-1:0]  dsor;

  logic [CNT_W:0]   trial;
  logic [CNT_W:0]   diff;
  logic             fits;
  logic [CNT_W-1:0] rem_next;

  // The dividend shifts out of the top of quo while quotient bits enter below.
  always_comb begin
    trial    = {rem, quo[SUM_W-1]};
    diff     = trial - {1'b0, dsor};
    fits     = (trial >= {1'b0, dsor});
    rem_next = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(SUM_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= dividend;
      dsor <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[SUM_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

FILE: sv/rad_window.sv
// Circular sample store with write position, fill count and running sum.
// Depends on rad_pkg for the window length type.
module rad_window
  import rad_pkg::*;
#(
  parameter int MAX_WINDOW  = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                                clk,
  input  logic                                                rst,
  input  logic                                                clear,
  input  cfg_t                                                win_len,
  input  logic                                                take,
  input  logic [SAMPLE_BITS-1:0]                              sample,
  input  logic                                                commit,
  output logic [SAMPLE_BITS+$clog2(MAX_WINDOW)-1:0]           sum,
  output logic [$clog2(MAX_WINDOW+1)-1:0]                     count
);

  localparam int PTR_W = $clog2(MAX_WINDOW);
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = SAMPLE_BITS + PTR_W;
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  logic [SAMPLE_BITS-1:0] store [MAX_WINDOW];
  logic [PTR_W-1:0]       wr_pos;
  logic [CNT_W-1:0]       fill;
  logic [SUM_W-1:0]       acc;
  logic [SAMPLE_BITS-1:0] old_q;
  logic [SAMPLE_BITS-1:0] new_q;
  logic                   old_valid;

  logic [CMP_W-1:0] len_ext;
  logic [CNT_W-1:0] eff_len;
  logic [CNT_W-1:0] pos_inc;
  logic [PTR_W-1:0] wr_pos_next;

  // Length zero acts as one; lengths past the store depth saturate.
  always_comb begin
    len_ext = CMP_W'(win_len);
    if (len_ext == '0) begin
      eff_len = CNT_W'(1);
    end else if (len_ext > CMP_W'(MAX_WINDOW)) begin
      eff_len = CNT_W'(MAX_WINDOW);
    end else begin
      eff_len = len_ext[CNT_W-1:0];
    end
    pos_inc     = CNT_W'(wr_pos) + CNT_W'(1);
    wr_pos_next = (pos_inc >= eff_len) ? '0 : pos_inc[PTR_W-1:0];
  end

  // Slots are written in order from zero after every clear, so the slot being
  // replaced holds a real sample only once the window is full. Before that it
  // counts as zero, which stands in for clearing the store.
  always_ff @(posedge clk) begin
    if (take) begin
      store[wr_pos] <= sample;
      old_q         <= store[wr_pos];
      new_q         <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      wr_pos    <= '0;
      fill      <= '0;
      acc       <= '0;
      old_valid <= 1'b0;
    end else begin
      if (take) begin
        wr_pos    <= wr_pos_next;
        old_valid <= (fill >= eff_len);
        if (fill < eff_len) begin
          fill <= fill + 1'b1;
        end
      end
      if (commit) begin
        acc <= acc - (old_valid ? SUM_W'(old_q) : '0) + SUM_W'(new_q);
      end
    end
  end

  assign sum   = acc;
  assign count = fill;

endmodule

FILE: sv/running_average_filter.sv
// Top level of the running average filter: handshakes, sequencer, output register.
// Depends on rad_pkg, rad_window and rad_divider.
//
//  Channel   Direction  Beat carries                        Handshake
//  s_axis    in         tdata = sample                      tvalid & tready
//  m_axis    out        tdata = average                     tvalid & tready
//  cfg       in         cfg_wdata = window_len              cfg_wen
//
// Each sample passes through the READ, ACC, DIV and OUT steps from its input beat
// until the average is in the output register; in DIV the restoring divider
// yields one quotient bit per cycle over the sum width.
// s_axis_tready is high only while the sequencer is idle. A finished average
// waits in the output register, so the next sample may be taken meanwhile; the
// divider result is held until that register is free.
// Reset and every configuration write empty the window.
module running_average_filter
  import rad_pkg::*;
#(
  parameter int MAX_WINDOW  = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wen,
  input  cfg_t                                cfg_wdata,       // window_len
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,    // sample, then zero fill
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_axis_tdata     // average, then zero fill
);

  localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_WINDOW);

  // Sequencer codes.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  cfg_t       window_len;

  logic             in_beat;
  logic             out_free;
  logic [SUM_W-1:0] win_sum;
  logic [CNT_W-1:0] fill_cnt;
  logic             div_start;
  logic             div_done;
  logic [SUM_W-1:0] quotient;

  assign s_axis_tready = (state == S_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign div_start     = (state == S_ACC);

  // The window register; a write also restarts the window inside rad_window.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= WINDOW_RESET;
    end else if (cfg_wen) begin
      window_len <= cfg_wdata;
    end
  end

  // IDLE takes a sample and reads the slot it replaces, READ updates the sum,
  // ACC launches the divider, DIV waits for it, OUT waits for the output slot.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_beat) begin
          state_next = S_READ;
        end
      end
      S_READ: state_next = S_ACC;
      S_ACC:  state_next = S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  rad_window #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_window (
    .clk     (clk),
    .rst     (rst),
    .clear   (cfg_wen),
    .win_len (window_len),
    .take    (in_beat),
    .sample  (s_axis_tdata[SAMPLE_BITS-1:0]),
    .commit  (state == S_READ),
    .sum     (win_sum),
    .count   (fill_cnt)
  );

  rad_divider #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (win_sum),
    .divisor  (fill_cnt),
    .done     (div_done),
    .quotient (quotient)
  );

  // Output register. The mean never exceeds the largest sample, so the low
  // SAMPLE_BITS of the quotient hold it whole.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      m_axis_tdata <= DATA_W'(quotient[SAMPLE_BITS-1:0]);
    end
  end

  // A taken sample closes the input until its average is stored.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> !s_axis_tready)
    else $error("input accepted while a sample is in flight");

  // The divisor is never zero when a division is launched.
  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    div_start |-> fill_cnt != '0)
    else $error("division launched with an empty window");

  // The divider finishes only while the sequencer waits for it.
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside the divide step");

  // A new output beat appears only from the output step.
  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state) == S_OUT)
    else $error("output raised without a finished average");

endmodule

FILE: tb/tb_running_average_filter.sv
// Self-checking testbench for running_average_filter: streams samples, predicts each average.
// Depends on rad_pkg and the running_average_filter RTL with rad_window and rad_divider; needs no other files.
module tb_running_average_filter;
  import rad_pkg::*;

  localparam int MAX_WINDOW  = 32;
  localparam int SAMPLE_BITS = 16;
  localparam int DATA_W      = ((SAMPLE_BITS + 7) / 8) * 8;
  // Delay from an input beat until its average is ready.
  localparam int LATENCY     = 25;
  localparam int RANDOM_ITEMS = 950;
  localparam logic [15:0] SAMPLE_MAX = 16'hFFFF;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_wen = 1'b0;
  cfg_t              cfg_wdata = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata = '0;    // sample, then zero fill
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [DATA_W-1:0] m_axis_tdata;         // average, then zero fill

  running_average_filter #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Samples waiting to be driven, and the averages still owed by the block.
  logic [15:0] pending_samples[$];
  logic [15:0] expected_averages[$];

  // Idle knobs, in percent, changed only between phases.
  int send_idle_pct = 0;
  int sink_stall_pct = 0;
  int fail_count = 0;

  // The testbench's own copy of the filter state. It mirrors the block: a circular
  // store, the next slot, how many slots hold valid samples, and their sum.
  cfg_t            win_len_q;
  logic [15:0]     win_store[MAX_WINDOW];
  int              win_pos;
  int              win_fill;
  longint unsigned win_total;

  function automatic void clear_window();
    foreach (win_store[i]) win_store[i] = '0;
    win_pos = 0;
    win_fill = 0;
    win_total = 0;
  endfunction

  // Takes one sample into the predicted state and returns the average it yields.
  // A window length of zero acts as one; lengths above the store size saturate.
  function automatic logic [15:0] predict_average(input logic [15:0] sample);
    int span;
    int slot;
    span = int'(win_len_q);
    if (span < 1) span = 1;
    if (span > MAX_WINDOW) span = MAX_WINDOW;
    // The slot pointer is wrapped into the current window before use.
    slot = win_pos;
    if (slot >= span) slot = 0;
    win_total = win_total - win_store[slot] + sample;
    win_store[slot] = sample;
    slot++;
    if (slot >= span) slot = 0;
    win_pos = slot;
    // Until the window has filled, only the samples seen so far are averaged.
    if (win_fill < span) win_fill++;
    return 16'(win_total / longint'(win_fill));
  endfunction

  // Driver. A beat is held until it is taken; otherwise the next sample is offered
  // unless this cycle is chosen to idle. Each taken beat adds one expected average.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        expected_averages.push_back(predict_average(s_axis_tdata[15:0]));
      end
      if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= DATA_W'(pending_samples.pop_front());
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Monitor. Every output beat is checked against the oldest expected average,
  // and tready is dropped at random to stall the block's output register.
  logic [15:0] wanted_average;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_averages.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("ERROR: average %0d arrived with none expected", m_axis_tdata);
          end
        end else begin
          wanted_average = expected_averages.pop_front();
          if (m_axis_tdata !== DATA_W'(wanted_average)) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("ERROR: average expected %0d, got %0d", wanted_average, m_axis_tdata);
            end
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Returns once no sample is queued or on the bus and every average has come back.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_samples.size() != 0 || s_axis_tvalid || expected_averages.size() != 0);
  endtask

  // Writes the window length while the block is idle; the write also empties the
  // window, so the predicted state is cleared at the same edge.
  task automatic write_window(input cfg_t value);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    win_len_q = value;
    clear_window();
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(negedge clk);
  endtask

  // Stimulus. A directed run at the reset window length, then phases that each
  // write a new length and send a burst of samples with a full drain halfway.
  initial begin
    int   phase;
    int   sent;
    int   count;
    int   span;
    int   style;
    cfg_t len;

    win_len_q = WINDOW_RESET;
    clear_window();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Window of 20 from reset: fill it with maximal samples and wrap once, so the
    // sum peaks and the oldest sample is replaced; then the other extremes.
    repeat (21) pending_samples.push_back(SAMPLE_MAX);
    pending_samples.push_back(16'd0);
    pending_samples.push_back(16'd1);
    pending_samples.push_back(16'h8000);
    pending_samples.push_back(16'hFFFE);
    wait_drained();

    phase = 0;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      // The first phases cover the shortest and longest windows, zero, the all-ones
      // value and just above the store size; the rest pick any register value.
      case (phase)
        0:       len = 6'd1;
        1:       len = 6'd32;
        2:       len = 6'd0;
        3:       len = 6'd63;
        4:       len = 6'd33;
        5:       len = 6'd2;
        6:       len = 6'd31;
        default: len = cfg_t'($urandom_range(0, 63));
      endcase
      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          sink_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 45;
          sink_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          sink_stall_pct = 45;
        end
        default: begin
          send_idle_pct = 31;
          sink_stall_pct = 31;
        end
      endcase
      write_window(len);

      span = int'(len);
      if (span < 1) span = 1;
      if (span > MAX_WINDOW) span = MAX_WINDOW;
      // Early phases open with a full window of maximal samples plus a wrap.
      if (phase < 7) begin
        repeat (span + 2) pending_samples.push_back(SAMPLE_MAX);
        sent += span + 2;
      end

      count = $urandom_range(30, 90);
      for (int i = 0; i < count; i++) begin
        if (i == count / 2) wait_drained();
        style = $urandom_range(0, 9);
        if (style < 4) pending_samples.push_back(16'($urandom_range(0, 65535)));
        else if (style < 6) pending_samples.push_back(SAMPLE_MAX - 16'($urandom_range(0, 3)));
        else if (style < 7) pending_samples.push_back(16'd0);
        else pending_samples.push_back(16'($urandom_range(0, 255)));
      end
      sent += count;
      wait_drained();
      phase++;
    end

    // Let any stray beat surface before the verdict.
    repeat (2 * LATENCY) @(posedge clk);
    if (fail_count == 0 && expected_averages.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run with every stall at its worst.
  initial begin
    #5000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: sim.f
sv/rad_pkg.sv
sv/rad_divider.sv
sv/rad_window.sv
sv/running_average_filter.sv
tb/tb_running_average_filter.sv
